@@ rtl/frame_interval_rate_meter_top_defines.svh @@
// assertion macros for the frame interval rate meter
// used by the top level only; needs nothing else

`ifndef FRAME_INTERVAL_RATE_METER_TOP_DEFINES_SVH
`define FRAME_INTERVAL_RATE_METER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FRM_ASSERT_IMPL(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("frame interval rate meter check failed");

// next-cycle implication, disabled during reset
`define FRM_ASSERT_NEXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("frame interval rate meter check failed");

`endif

@@ rtl/frm_pkg.sv @@
// shared constants and types of the frame interval rate meter
// no dependencies

package frm_pkg;

  localparam int STAMP_W   = 32;
  localparam int THOU_W    = 23;
  localparam int RATE_W    = 32;
  localparam int RATE_FRAC = 8;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // floor(x / 1000) == (x * RECIP_1000) >> THOU_SHIFT for every 32-bit x
  localparam int          RECIP_W    = 29;
  localparam int          THOU_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_SECOND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TICK        = 1'd1;

  localparam logic [CFG_W-1:0]   CPS_RESET   = 32'd10000000;
  localparam logic [STAMP_W-1:0] START_RESET = 32'd0;

  typedef struct packed {
    logic busy;
    logic ovf;
  } frm_div_stat_t;

endpackage

@@ rtl/frm_ifs.sv @@
// handshake channels of the frame interval rate meter
// depends on frm_pkg

interface frm_in_if;
  import frm_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] timestamp;

  modport source (output valid, output timestamp, input ready);
  modport sink (input valid, input timestamp, output ready);
endinterface

interface frm_out_if;
  import frm_pkg::*;
  logic              valid;
  logic              ready;
  logic [THOU_W-1:0] interval_thousandths;
  logic [RATE_W-1:0] frame_rate;

  modport source (output valid, output interval_thousandths, output frame_rate, input ready);
  modport sink (input valid, input interval_thousandths, input frame_rate, output ready);
endinterface

@@ rtl/frm_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module frm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/frm_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// depends on frm_pkg for the status struct

module frm_div #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 38,
  parameter int Q_W   = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NUM_W-1:0]           numer,
  input  logic [DEN_W-1:0]           denom,
  output logic [Q_W-1:0]             quotient,
  output frm_pkg::frm_div_stat_t     stat
);
  import frm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
      rem  <= '0;
      quo  <= numer;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(trial - {1'b0, denom}) : trial[DEN_W-1:0];
      quo  <= {quo[NUM_W-2:0], fits};
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient  = quo[Q_W-1:0];
  assign stat.busy = busy;
  assign stat.ovf  = |quo[NUM_W-1:Q_W];

endmodule

@@ rtl/frame_interval_rate_meter_top.sv @@
// top level of the frame interval rate meter: sequencer, ring memory, divider
// depends on frm_pkg, frm_ifs, frm_ram, frm_div and the defines header

// One timestamp word gives one result word: the interval since the previous
// frame in thousands of counts and the average frame rate over the last
// (up to) WINDOW intervals as unsigned 24.8 fixed point, saturated. An item
// passes from acceptance through ST_RD, ST_MUL, ST_START, ST_DIV and ST_DONE
// to a waiting result; the bit-serial divider, one quotient bit per cycle,
// divides a numerator of NUM_W = 40 + clog2(WINDOW + 1) bits. A new
// timestamp is taken as soon as the previous result sits in the output
// register. The interval ring lives in one ram; entries not yet written
// since reset are masked by the fill count, so no clearing pass follows reset.

`include "frame_interval_rate_meter_top_defines.svh"

module frame_interval_rate_meter_top #(
  parameter int WINDOW = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [frm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frm_pkg::CFG_W-1:0]    cfg_data,
  frm_in_if.sink                       samples,
  frm_out_if.source                    results
);
  import frm_pkg::*;

  localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int SUM_W = STAMP_W + PW;
  localparam int CF_W  = CFG_W + FW;
  localparam int NUM_W = CF_W + RATE_FRAC;
  localparam int PROD_W = STAMP_W + RECIP_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state;
  logic [CFG_W-1:0]   counts_per_second;
  logic [STAMP_W-1:0] prev_stamp;
  logic [SUM_W-1:0]   window_sum;
  logic [PW-1:0]      ring_pos;
  logic [FW-1:0]      fill_count;
  logic [STAMP_W-1:0] stamp_diff;
  logic [PROD_W-1:0]  thou_prod;
  logic [THOU_W-1:0]  thou;
  logic [NUM_W-1:0]   numer;
  logic               out_valid;
  logic [THOU_W-1:0]  out_thou;
  logic [RATE_W-1:0]  out_rate;

  logic               accept;
  logic               ring_full;
  logic [STAMP_W-1:0] ring_rdata;
  logic [STAMP_W-1:0] old_entry;
  logic [STAMP_W-1:0] stored;
  logic               ring_we;
  logic               div_start;
  logic [RATE_W-1:0]  div_q;
  frm_div_stat_t      div_stat;
  logic               out_free;

  assign accept    = samples.valid && samples.ready;
  assign ring_full = fill_count >= FW'(WINDOW);
  assign old_entry = ring_full ? ring_rdata : '0;
  assign stored    = (stamp_diff == '0) ? STAMP_W'(1) : stamp_diff;
  assign ring_we   = state == ST_RD;
  assign div_start = state == ST_START;
  assign out_free  = !out_valid || results.ready;

  assign samples.ready                = state == ST_IDLE;
  assign results.valid                = out_valid;
  assign results.interval_thousandths = out_thou;
  assign results.frame_rate           = out_rate;

  frm_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_pos),
    .wdata (stored),
    .re    (accept),
    .raddr (ring_pos),
    .rdata (ring_rdata)
  );

  frm_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W),
    .Q_W   (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .denom    (window_sum),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      counts_per_second <= CPS_RESET;
      prev_stamp        <= START_RESET;
      window_sum        <= '0;
      ring_pos          <= '0;
      fill_count        <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            stamp_diff <= samples.timestamp - prev_stamp;
            prev_stamp <= samples.timestamp;
            state      <= ST_RD;
          end
        end
        ST_RD: begin
          window_sum <= window_sum + SUM_W'(stored) - SUM_W'(old_entry);
          ring_pos   <= (ring_pos == PW'(WINDOW - 1)) ? '0 : ring_pos + 1'b1;
          if (!ring_full) begin
            fill_count <= fill_count + 1'b1;
          end
          thou_prod <= {{RECIP_W{1'b0}}, stamp_diff} * {{STAMP_W{1'b0}}, RECIP_1000};
          state     <= ST_MUL;
        end
        ST_MUL: begin
          numer <= {(CF_W'(counts_per_second) * CF_W'(fill_count)), {RATE_FRAC{1'b0}}};
          thou  <= thou_prod[THOU_SHIFT +: THOU_W];
          state <= ST_START;
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (!div_stat.busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_thou  <= thou;
            out_rate  <= div_stat.ovf ? '1 : div_q;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_we) begin
        case (cfg_index)
          REG_COUNTS_PER_SECOND: begin
            counts_per_second <= cfg_data;
          end
          REG_START_TICK: begin
            if (fill_count == '0) begin
              prev_stamp <= cfg_data;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  `FRM_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, fill_count <= FW'(WINDOW))
  `FRM_ASSERT_IMPL(a_sum_floor, clk, rst, 1'b1, window_sum >= SUM_W'(fill_count))
  `FRM_ASSERT_NEXT(a_accept_reads, clk, rst, accept, state == ST_RD)
  `FRM_ASSERT_NEXT(a_div_runs, clk, rst, state == ST_START, div_stat.busy)

endmodule
